// ===== rtl/bctp_pkg.sv =====
package bctp_pkg;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF    = 16;
  localparam int COUNT_MAX_DEF = 65535;
  localparam int DEV_BITS_DEF = 4;

  // Fixed widths and limits
  localparam int CNT_W    = 16;
  localparam int SYNC_MAX = 16;
  localparam int FQ_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FREE  = 2'd2,
    OP_SYNC  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  dev;
    logic [31:0] block_num;
  } in_t;

  typedef struct packed {
    logic        status;
    logic        hit;
    logic [3:0]  slot;
    logic        fill_needed;
    logic        writeback_needed;
    logic [3:0]  wb_dev;
    logic [31:0] wb_block;
    logic        last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/block_cache_tag_policy.sv =====
// Tag and replacement engine for a disk buffer cache. Requests (read, write,
// free, sync) enter a two-deep queue; a scan engine then visits every slot
// in turn, with a read state and an evaluate state per slot because the tag
// memory has a registered read, and it may also wait for the result side.
// Read, write and free give one result; sync gives one result per dirty
// slot of the device (at most 16), or one result if there is none, the last
// one flagged. Results wait in an output register while the next request is
// queued. Tag memory needs no clearing after reset.
module block_cache_tag_policy #(
  parameter int SLOTS     = bctp_pkg::SLOTS_DEF,
  parameter int COUNT_MAX = bctp_pkg::COUNT_MAX_DEF,
  parameter int DEV_BITS  = bctp_pkg::DEV_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  bctp_pkg::in_t  in_data,
  output logic           out_empty,
  input  logic           out_pop,
  output bctp_pkg::out_t out_data
);

  logic          req_vld;
  logic          req_pop;
  bctp_pkg::in_t req;

  bctp_front #(.DEV_BITS(DEV_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .req_vld (req_vld),
    .req_pop (req_pop),
    .req     (req)
  );

  bctp_back #(
    .SLOTS     (SLOTS),
    .COUNT_MAX (COUNT_MAX),
    .DEV_BITS  (DEV_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_vld   (req_vld),
    .req_pop   (req_pop),
    .req       (req),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // A no-victim result stands alone and reports nothing else
  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status) |-> (out_data.last && !out_data.hit
      && !out_data.writeback_needed && !out_data.fill_needed))
    else $error("no-victim result carries other fields");

  // A fill only follows a read miss, which ends its request
  a_fill_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.fill_needed) |-> (!out_data.hit && out_data.last))
    else $error("fill on a hit or non-final result");

  // Without a writeback the writeback address is zero
  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.writeback_needed)
      |-> (out_data.wb_dev == 4'd0 && out_data.wb_block == 32'd0))
    else $error("writeback address without writeback");

endmodule

// ===== rtl/bctp_front.sv =====
module bctp_front #(
  parameter int DEV_BITS = bctp_pkg::DEV_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  bctp_pkg::in_t  in_data,
  output logic           req_vld,
  input  logic           req_pop,
  output bctp_pkg::in_t  req
);

  localparam int PW = (bctp_pkg::FQ_DEPTH > 1) ? $clog2(bctp_pkg::FQ_DEPTH) : 1;
  localparam int CW = $clog2(bctp_pkg::FQ_DEPTH + 1);
  localparam int DM = (DEV_BITS >= 4) ? 15 : ((1 << DEV_BITS) - 1);
  localparam logic [3:0] DEV_MASK = 4'(DM);
  localparam logic [PW-1:0] LAST_P = PW'(bctp_pkg::FQ_DEPTH - 1);

  bctp_pkg::in_t  q_r [bctp_pkg::FQ_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           push_ok;
  logic           pop_ok;
  bctp_pkg::in_t  cls;

  // Classify: keep only the device bits this cache tracks
  always_comb begin
    cls     = in_data;
    cls.dev = in_data.dev & DEV_MASK;
  end

  assign in_full = (cnt_r == CW'(bctp_pkg::FQ_DEPTH));
  assign req_vld = (cnt_r != '0);
  assign req     = q_r[rp_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = req_pop && req_vld;

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = push_ok ? ((wp_r == LAST_P) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = pop_ok ? ((rp_r == LAST_P) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CW'(push_ok) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold queued transactions
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

// ===== rtl/bctp_back.sv =====
module bctp_back #(
  parameter int SLOTS     = bctp_pkg::SLOTS_DEF,
  parameter int COUNT_MAX = bctp_pkg::COUNT_MAX_DEF,
  parameter int DEV_BITS  = bctp_pkg::DEV_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_vld,
  output logic           req_pop,
  input  bctp_pkg::in_t  req,
  output logic           out_empty,
  input  logic           out_pop,
  output bctp_pkg::out_t out_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = bctp_pkg::CNT_W;
  localparam int NW = $clog2(bctp_pkg::SYNC_MAX + 1);
  localparam logic [CW-1:0] CMAX = CW'(COUNT_MAX);
  localparam logic [SW-1:0] LAST_S = SW'(SLOTS - 1);

  function automatic logic [3:0] slot4(input logic [SW-1:0] s);
    logic [SW+3:0] e;
    e = {4'b0, s};
    return e[3:0];
  endfunction

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (c < CMAX) ? c + 1'b1 : CMAX;
  endfunction

  // Tag and count memory
  logic [31:0]         mem_blk [SLOTS];
  logic [DEV_BITS-1:0] mem_dev [SLOTS];
  logic [CW-1:0]       mem_cnt [SLOTS];
  logic [31:0]         rd_blk_r;
  logic [DEV_BITS-1:0] rd_dev_r;
  logic [CW-1:0]       rd_cnt_r;

  logic [SLOTS-1:0] valid_r, dirty_r;
  logic [CW-1:0]    hc_r, hcw_r;

  bctp_pkg::state_t state_r, state_nxt;
  bctp_pkg::in_t    req_r;
  logic [SW-1:0]    idx_r;

  logic          found_r, mdirty_r;
  logic [SW-1:0] m_r;
  logic [CW-1:0] mcnt_r;
  logic          ffound_r;
  logic [SW-1:0] f_r;
  logic          cfound_r;
  logic [SW-1:0] c_r;
  logic [CW-1:0] lc_r;
  logic          dfound_r;
  logic [SW-1:0] d_r;
  logic [CW-1:0] ld_r;
  logic [3:0]    ddev_r;
  logic [31:0]   dblk_r;

  logic [NW-1:0] n_r;
  logic          pend_r;
  logic [SW-1:0] pslot_r;
  logic [31:0]   pblk_r;

  logic           out_vld_r;
  bctp_pkg::out_t out_r;

  // Comparisons on the slot under evaluation
  logic [DEV_BITS+3:0] dev_ext;
  logic [DEV_BITS-1:0] req_tag;
  logic [DEV_BITS+3:0] rdev_ext;
  logic                cur_v, cur_d, dev_eq, is_match, scanned, sync_q;
  logic                is_sync, out_free, ev_stall, last_slot;

  assign dev_ext   = {{DEV_BITS{1'b0}}, req_r.dev};
  assign req_tag   = dev_ext[DEV_BITS-1:0];
  assign rdev_ext  = {4'b0, rd_dev_r};
  assign cur_v     = valid_r[idx_r];
  assign cur_d     = dirty_r[idx_r];
  assign dev_eq    = (rd_dev_r == req_tag);
  assign is_match  = cur_v && dev_eq && (rd_blk_r == req_r.block_num);
  assign scanned   = !ffound_r && cur_v;
  assign is_sync   = (req_r.op == bctp_pkg::OP_SYNC);
  assign sync_q    = is_sync && cur_v && cur_d && dev_eq
                     && (n_r < NW'(bctp_pkg::SYNC_MAX));
  assign out_free  = !out_vld_r || out_pop;
  assign ev_stall  = sync_q && pend_r && !out_free;
  assign last_slot = (idx_r == LAST_S);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bctp_pkg::ST_IDLE: if (req_vld) state_nxt = bctp_pkg::ST_RD;
      bctp_pkg::ST_RD:   state_nxt = bctp_pkg::ST_EV;
      bctp_pkg::ST_EV: begin
        if (!ev_stall) state_nxt = last_slot ? bctp_pkg::ST_FIN : bctp_pkg::ST_RD;
      end
      bctp_pkg::ST_FIN:  if (out_free) state_nxt = bctp_pkg::ST_IDLE;
      default:           state_nxt = bctp_pkg::ST_IDLE;
    endcase
  end

  // Actions: result, memory write, flag update, count commit
  logic           emit;
  bctp_pkg::out_t emit_d;
  logic           mem_we;
  logic [SW-1:0]  we_addr;
  logic [31:0]    we_blk;
  logic [DEV_BITS-1:0] we_dev;
  logic [CW-1:0]  we_cnt;
  logic           vd_we, vd_valid, vd_dirty;
  logic           hc_we;
  logic [CW-1:0]  hc_new;
  logic [CW-1:0]  hc_inc;
  logic [SW-1:0]  vic;
  logic           vic_ok;

  assign hc_inc = sat_inc(hcw_r);

  always_comb begin
    emit     = 1'b0;
    emit_d   = '0;
    mem_we   = 1'b0;
    we_addr  = idx_r;
    we_blk   = req_r.block_num;
    we_dev   = req_tag;
    we_cnt   = sat_inc(rd_cnt_r);
    vd_we    = 1'b0;
    vd_valid = 1'b1;
    vd_dirty = 1'b0;
    hc_we    = 1'b0;
    hc_new   = hcw_r;
    req_pop  = 1'b0;
    vic_ok   = ffound_r || cfound_r || dfound_r;
    vic      = ffound_r ? f_r : (cfound_r ? c_r : d_r);
    unique case (state_r)
      bctp_pkg::ST_IDLE: req_pop = req_vld;
      bctp_pkg::ST_RD: ;
      bctp_pkg::ST_EV: begin
        if (sync_q && !ev_stall) begin
          // Release the previous dirty slot, clean this one
          emit                    = pend_r;
          emit_d.hit              = 1'b1;
          emit_d.slot             = slot4(pslot_r);
          emit_d.writeback_needed = 1'b1;
          emit_d.wb_dev           = req_r.dev;
          emit_d.wb_block         = pblk_r;
          mem_we                  = 1'b1;
          we_blk                  = rd_blk_r;
          we_dev                  = rd_dev_r;
          vd_we                   = 1'b1;
          vd_valid                = 1'b1;
          vd_dirty                = 1'b0;
        end
      end
      bctp_pkg::ST_FIN: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_d.last = 1'b1;
          if (is_sync) begin
            if (pend_r) begin
              emit_d.hit              = 1'b1;
              emit_d.slot             = slot4(pslot_r);
              emit_d.writeback_needed = 1'b1;
              emit_d.wb_dev           = req_r.dev;
              emit_d.wb_block         = pblk_r;
            end
          end else if (req_r.op == bctp_pkg::OP_FREE) begin
            if (found_r) begin
              emit_d.hit              = 1'b1;
              emit_d.slot             = slot4(m_r);
              emit_d.writeback_needed = mdirty_r;
              emit_d.wb_dev           = mdirty_r ? req_r.dev : 4'd0;
              emit_d.wb_block         = mdirty_r ? req_r.block_num : 32'd0;
              vd_we                   = 1'b1;
              we_addr                 = m_r;
              vd_valid                = 1'b0;
              vd_dirty                = 1'b0;
            end
          end else if (found_r) begin
            // Hit: bump the count, mark dirty on write
            emit_d.hit  = 1'b1;
            emit_d.slot = slot4(m_r);
            mem_we      = 1'b1;
            we_addr     = m_r;
            we_cnt      = sat_inc(mcnt_r);
            vd_we       = 1'b1;
            vd_valid    = 1'b1;
            vd_dirty    = mdirty_r || (req_r.op == bctp_pkg::OP_WRITE);
          end else if (!vic_ok) begin
            emit_d.status = 1'b1;
            hc_we         = 1'b1;
            hc_new        = hcw_r;
          end else begin
            // Miss: take over the victim
            emit_d.slot             = slot4(vic);
            emit_d.fill_needed      = (req_r.op == bctp_pkg::OP_READ);
            emit_d.writeback_needed = !ffound_r && !cfound_r;
            emit_d.wb_dev           = (!ffound_r && !cfound_r) ? ddev_r : 4'd0;
            emit_d.wb_block         = (!ffound_r && !cfound_r) ? dblk_r : 32'd0;
            hc_we                   = 1'b1;
            hc_new                  = hc_inc;
            mem_we                  = 1'b1;
            we_addr                 = vic;
            we_cnt                  = hc_inc;
            vd_we                   = 1'b1;
            vd_valid                = 1'b1;
            vd_dirty                = (req_r.op == bctp_pkg::OP_WRITE);
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bctp_pkg::ST_IDLE;
      valid_r   <= '0;
      dirty_r   <= '0;
      hc_r      <= '0;
      out_vld_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= emit || (out_vld_r && !out_pop);
      if (vd_we) begin
        valid_r[we_addr] <= vd_valid;
        dirty_r[we_addr] <= vd_dirty;
      end
      if (hc_we) hc_r <= hc_new;
      if (state_r == bctp_pkg::ST_IDLE) begin
        pend_r <= 1'b0;
      end else if (state_r == bctp_pkg::ST_EV && sync_q && !ev_stall) begin
        pend_r <= 1'b1;
      end
    end
  end

  // Memory port and read register
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_blk[we_addr] <= we_blk;
      mem_dev[we_addr] <= we_dev;
      mem_cnt[we_addr] <= we_cnt;
    end
    if (state_r == bctp_pkg::ST_RD) begin
      rd_blk_r <= mem_blk[idx_r];
      rd_dev_r <= mem_dev[idx_r];
      rd_cnt_r <= mem_cnt[idx_r];
    end
  end

  // Scan accumulators
  always_ff @(posedge clk) begin
    if (emit) out_r <= emit_d;
    unique case (state_r)
      bctp_pkg::ST_IDLE: begin
        req_r    <= req;
        idx_r    <= '0;
        hcw_r    <= hc_r;
        found_r  <= 1'b0;
        ffound_r <= 1'b0;
        cfound_r <= 1'b0;
        dfound_r <= 1'b0;
        lc_r     <= CMAX;
        ld_r     <= CMAX;
        n_r      <= '0;
      end
      bctp_pkg::ST_EV: begin
        if (!ev_stall) begin
          if (!last_slot) idx_r <= idx_r + 1'b1;
          if (is_match && !found_r) begin
            found_r  <= 1'b1;
            m_r      <= idx_r;
            mcnt_r   <= rd_cnt_r;
            mdirty_r <= cur_d;
          end
          if (!cur_v && !ffound_r) begin
            ffound_r <= 1'b1;
            f_r      <= idx_r;
          end
          if (scanned) begin
            if (rd_cnt_r > hcw_r) hcw_r <= rd_cnt_r;
            if (!cur_d && rd_cnt_r < lc_r) begin
              cfound_r <= 1'b1;
              c_r      <= idx_r;
              lc_r     <= rd_cnt_r;
            end
            if (cur_d && rd_cnt_r < ld_r) begin
              dfound_r <= 1'b1;
              d_r      <= idx_r;
              ld_r     <= rd_cnt_r;
              ddev_r   <= rdev_ext[3:0];
              dblk_r   <= rd_blk_r;
            end
          end
          if (sync_q) begin
            n_r     <= n_r + 1'b1;
            pslot_r <= idx_r;
            pblk_r  <= rd_blk_r;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_empty = !out_vld_r;
  assign out_data  = out_r;

endmodule
